// ===== rtl/palindromic_tree_builder_core_assert.svh =====
// assertion macros shared by the core
`ifndef PALINDROMIC_TREE_BUILDER_CORE_ASSERT_SVH
`define PALINDROMIC_TREE_BUILDER_CORE_ASSERT_SVH

// same-cycle implication
`define PTB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptb assertion failed");

// next-cycle implication
`define PTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptb assertion failed");

`endif

// ===== rtl/ptb_pkg.sv =====
package ptb_pkg;

  localparam int MAX_LEN    = 1024;
  localparam int ALPHABET   = 26;
  localparam int NODE_DEPTH = MAX_LEN + 3;
  localparam int EDGE_DEPTH = NODE_DEPTH * ALPHABET;
  localparam int NW         = 11;
  localparam int TAW        = 10;
  localparam int EAW        = 15;
  localparam int CW         = 5;

  localparam logic [NW-1:0] ROOT_IMAG  = 11'd1;
  localparam logic [NW-1:0] ROOT_EMPTY = 11'd2;
  localparam logic [NW-1:0] FIRST_NODE = 11'd3;

  typedef struct packed {
    logic [4:0] letter;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [10:0] pal_len;
    logic [9:0]  pal_start;
    logic        is_new;
    logic [10:0] pal_id;
    logic [10:0] distinct_count;
    logic        overflow;
  } result_t;

  typedef struct packed {
    logic [NW-1:0] len;
    logic [NW-1:0] link;
    logic [NW-1:0] parent;
    logic [CW-1:0] chr;
  } node_t;

endpackage

// ===== rtl/ptb_ram.sv =====
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/palindromic_tree_builder_core.sv =====
// channel | valid        | stall        | word
// item    | item_valid   | item_stall   | item   (letter, restart)
// result  | result_valid | result_stall | result (one per item)
// a letter walks the suffix links (S_WN, S_WT, S_WC), looks up the child edge (S_EA, S_EB, S_EC), ends in S_FIN
// each link followed reads the node, then a text letter unless the node is too long for the text
// a new node of length two or more adds a second walk, plus its links, to find its suffix link
// a letter at capacity goes straight to S_FIN; restart costs nothing extra
// reset is synchronous and needs no clearing pass: child edges are checked
// against the parent and letter held in the node memory
// item_stall is high while a letter is at work; a stalled result holds the core in its last step
module palindromic_tree_builder_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  ptb_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_stall,
  output ptb_pkg::result_t result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WN   = 3'd1;
  localparam logic [2:0] S_WT   = 3'd2;
  localparam logic [2:0] S_WC   = 3'd3;
  localparam logic [2:0] S_EA   = 3'd4;
  localparam logic [2:0] S_EB   = 3'd5;
  localparam logic [2:0] S_EC   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state;
  logic [ptb_pkg::NW-1:0] pos, cur, cnt;
  logic [ptb_pkg::CW-1:0] c;
  logic [ptb_pkg::NW-1:0] n, n_link, k, l;
  logic [ptb_pkg::NW-1:0] a, a_len, a_link;
  logic a_imag, phase, l_ok, ovf, fresh;
  logic [ptb_pkg::NW-1:0] node_res, len_res, link_res;

  logic accept;
  logic [ptb_pkg::CW-1:0] c_sat;
  logic [ptb_pkg::NW-1:0] pos_e, cnt_e, cur_e;
  logic [ptb_pkg::NW-1:0] w_len, w_link, new_len;
  logic hit, out_free;

  logic text_we;
  logic [ptb_pkg::TAW-1:0] text_raddr;
  logic [ptb_pkg::CW-1:0] text_rdata;
  logic node_we;
  logic [ptb_pkg::NW-1:0] node_raddr;
  ptb_pkg::node_t node_wdata, node_rd;
  logic edge_we;
  logic [ptb_pkg::EAW-1:0] edge_raddr, edge_waddr;
  logic [ptb_pkg::NW-1:0] edge_rdata;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    c_sat = (item.letter >= 5'(ptb_pkg::ALPHABET)) ? 5'(ptb_pkg::ALPHABET - 1) : item.letter;
    pos_e = item.restart ? '0 : pos;
    cnt_e = item.restart ? ptb_pkg::ROOT_EMPTY : cnt;
    cur_e = item.restart ? ptb_pkg::ROOT_IMAG : cur;
    if (n == ptb_pkg::ROOT_EMPTY) begin
      w_len  = '0;
      w_link = ptb_pkg::ROOT_IMAG;
    end else begin
      w_len  = node_rd.len;
      w_link = node_rd.link;
    end
    text_raddr = ptb_pkg::TAW'(pos - w_len - 11'd1);
    node_raddr = (state == S_EB) ? edge_rdata : n;
    edge_raddr = ptb_pkg::EAW'(k) * ptb_pkg::EAW'(ptb_pkg::ALPHABET) + ptb_pkg::EAW'(c);
    edge_waddr = ptb_pkg::EAW'(a) * ptb_pkg::EAW'(ptb_pkg::ALPHABET) + ptb_pkg::EAW'(c);
    hit        = l_ok && (node_rd.parent == k) && (node_rd.chr == c);
    new_len    = a_imag ? 11'd1 : a_len + 11'd2;
    text_we    = accept && (pos_e < 11'(ptb_pkg::MAX_LEN));
    node_we    = (state == S_FIN) && out_free && !ovf && fresh;
    edge_we    = node_we;
    node_wdata = '{len: len_res, link: link_res, parent: a, chr: c};
  end

  ptb_ram #(.WIDTH(ptb_pkg::CW), .DEPTH(ptb_pkg::MAX_LEN)) u_text (
    .clk(clk), .we(text_we), .waddr(pos_e[ptb_pkg::TAW-1:0]), .wdata(c_sat),
    .raddr(text_raddr), .rdata(text_rdata)
  );

  ptb_ram #(.WIDTH($bits(ptb_pkg::node_t)), .DEPTH(ptb_pkg::NODE_DEPTH)) u_node (
    .clk(clk), .we(node_we), .waddr(cnt + 11'd1), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rd)
  );

  ptb_ram #(.WIDTH(ptb_pkg::NW), .DEPTH(ptb_pkg::EDGE_DEPTH)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(cnt + 11'd1),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= '0;
      cur          <= ptb_pkg::ROOT_IMAG;
      cnt          <= ptb_pkg::ROOT_EMPTY;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_FIN)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            c     <= c_sat;
            pos   <= pos_e;
            cnt   <= cnt_e;
            cur   <= cur_e;
            n     <= cur_e;
            phase <= 1'b0;
            ovf   <= (pos_e >= 11'(ptb_pkg::MAX_LEN));
            state <= (pos_e >= 11'(ptb_pkg::MAX_LEN)) ? S_FIN : S_WN;
          end
        end
        S_WN: begin
          state <= S_WT;
        end
        S_WT: begin
          n_link <= w_link;
          if (n == ptb_pkg::ROOT_IMAG) begin
            k     <= n;
            state <= S_EA;
            if (!phase) begin
              a      <= n;
              a_imag <= 1'b1;
              a_len  <= '0;
              a_link <= ptb_pkg::ROOT_IMAG;
            end
          end else if (pos > w_len) begin
            if (!phase) begin
              a_len  <= w_len;
              a_link <= w_link;
            end
            state <= S_WC;
          end else begin
            n     <= w_link;
            state <= S_WN;
          end
        end
        S_WC: begin
          if (text_rdata == c) begin
            k     <= n;
            state <= S_EA;
            if (!phase) begin
              a      <= n;
              a_imag <= 1'b0;
            end
          end else begin
            n     <= n_link;
            state <= S_WN;
          end
        end
        S_EA: begin
          state <= S_EB;
        end
        S_EB: begin
          l     <= edge_rdata;
          l_ok  <= (edge_rdata >= ptb_pkg::FIRST_NODE) && (edge_rdata <= cnt);
          state <= S_EC;
        end
        S_EC: begin
          if (phase) begin
            if (hit) begin
              link_res <= l;
            end else begin
              link_res <= ptb_pkg::ROOT_EMPTY;
            end
            state <= S_FIN;
          end else if (hit) begin
            node_res <= l;
            len_res  <= node_rd.len;
            fresh    <= 1'b0;
            state    <= S_FIN;
          end else begin
            node_res <= cnt + 11'd1;
            len_res  <= new_len;
            fresh    <= 1'b1;
            if (new_len == 11'd1) begin
              link_res <= ptb_pkg::ROOT_EMPTY;
              state    <= S_FIN;
            end else begin
              phase <= 1'b1;
              n     <= a_link;
              state <= S_WN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
            if (ovf) begin
              result <= '{pal_len: '0, pal_start: '0, is_new: 1'b0, pal_id: '0,
                          distinct_count: cnt - 11'd2, overflow: 1'b1};
            end else begin
              result <= '{pal_len: len_res,
                          pal_start: 10'(pos + 11'd1 - len_res),
                          is_new: fresh,
                          pal_id: node_res - 11'd2,
                          distinct_count: cnt + 11'(fresh) - 11'd2,
                          overflow: 1'b0};
              cnt <= cnt + 11'(fresh);
              cur <= node_res;
              pos <= pos + 11'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "palindromic_tree_builder_core_assert.svh"

  `PTB_ASSERT_NOW(a_new_id, result_valid && result.is_new, result.pal_id == result.distinct_count)
  `PTB_ASSERT_NOW(a_len_nz, result_valid && !result.overflow, result.pal_len != 11'd0)
  `PTB_ASSERT_NEXT(a_busy, accept, state != S_IDLE)
  `PTB_ASSERT_NOW(a_pos_cap, 1'b1, pos <= 11'(ptb_pkg::MAX_LEN) && cnt >= ptb_pkg::ROOT_EMPTY)

endmodule

// ===== bench/palindromic_tree_builder_core_test.sv =====
`timescale 1ns / 1ps

module palindromic_tree_builder_core_test;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  ptb_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  ptb_pkg::result_t result;

  palindromic_tree_builder_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #4 clk = ~clk;

  // shadow copy of the tree
  int text_mem [ptb_pkg::MAX_LEN];
  int len_of [ptb_pkg::NODE_DEPTH];
  int link_of [ptb_pkg::NODE_DEPTH];
  int edge_to [ptb_pkg::EDGE_DEPTH];
  int text_pos, longest_node, node_total;
  ptb_pkg::result_t pending_results[$];
  bit failed = 0;
  bit quiet = 0;

  function automatic void wipe_tree();
    foreach (text_mem[i]) text_mem[i] = 0;
    foreach (len_of[i]) len_of[i] = 0;
    foreach (link_of[i]) link_of[i] = 0;
    foreach (edge_to[i]) edge_to[i] = 0;
    len_of[ptb_pkg::ROOT_IMAG] = -1;
    len_of[ptb_pkg::ROOT_EMPTY] = 0;
    link_of[ptb_pkg::ROOT_IMAG] = int'(ptb_pkg::ROOT_IMAG);
    link_of[ptb_pkg::ROOT_EMPTY] = int'(ptb_pkg::ROOT_IMAG);
    text_pos = 0;
    longest_node = int'(ptb_pkg::ROOT_IMAG);
    node_total = 2;
  endfunction

  function automatic int valid_node(int n);
    return (n >= 0 && n < ptb_pkg::NODE_DEPTH) ? n : int'(ptb_pkg::ROOT_IMAG);
  endfunction

  function automatic bit wraps(int n, int p, int c);
    int idx;
    idx = p - len_of[n] - 1;
    if (idx < 0 || idx > p) return 0;
    return text_mem[idx] == c;
  endfunction

  function automatic int follow_links(int n, int p, int c);
    int guard;
    guard = 0;
    n = valid_node(n);
    while (!wraps(n, p, c) && n != int'(ptb_pkg::ROOT_IMAG) &&
           guard <= ptb_pkg::NODE_DEPTH) begin
      n = valid_node(link_of[n]);
      guard++;
    end
    return n;
  endfunction

  function automatic ptb_pkg::result_t predict_suffix(ptb_pkg::item_t w);
    ptb_pkg::result_t r;
    int c, a, b, nd, l;
    bit fresh;
    r = '0;
    fresh = 0;
    c = int'(w.letter);
    if (c >= ptb_pkg::ALPHABET) c = ptb_pkg::ALPHABET - 1;
    if (w.restart) wipe_tree();
    if (text_pos >= ptb_pkg::MAX_LEN) begin
      r.distinct_count = 11'(node_total - 2);
      r.overflow = 1'b1;
      return r;
    end
    text_mem[text_pos] = c;
    a = follow_links(longest_node, text_pos, c);
    nd = edge_to[a * ptb_pkg::ALPHABET + c];
    if (nd == 0 || nd >= ptb_pkg::NODE_DEPTH) begin
      node_total++;
      nd = node_total;
      fresh = 1;
      edge_to[a * ptb_pkg::ALPHABET + c] = nd;
      len_of[nd] = len_of[a] + 2;
      if (len_of[nd] == 1) begin
        link_of[nd] = int'(ptb_pkg::ROOT_EMPTY);
      end else begin
        b = follow_links(link_of[a], text_pos, c);
        l = edge_to[b * ptb_pkg::ALPHABET + c];
        link_of[nd] = (l != 0 && l < ptb_pkg::NODE_DEPTH) ? l : int'(ptb_pkg::ROOT_EMPTY);
      end
    end
    longest_node = nd;
    r.pal_len = 11'(len_of[nd]);
    r.pal_start = 10'(text_pos + 1 - len_of[nd]);
    r.is_new = fresh;
    r.pal_id = 11'(nd - 2);
    r.distinct_count = 11'(node_total - 2);
    text_pos++;
    return r;
  endfunction

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 24);
  endfunction

  task automatic send_word(input int letter, input bit restart);
    ptb_pkg::item_t w;
    w.letter = 5'(letter);
    w.restart = restart;
    while (idle_now()) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (item_stall);
    pending_results.push_back(predict_suffix(w));
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      failed = 1;
    end
  endtask

  always @(posedge clk) begin
    ptb_pkg::result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word expected none actual %p", $time, result);
          failed = 1;
        end else begin
          want = pending_results.pop_front();
          check_field("pal_len", int'(want.pal_len), int'(result.pal_len));
          check_field("pal_start", int'(want.pal_start), int'(result.pal_start));
          check_field("is_new", int'(want.is_new), int'(result.is_new));
          check_field("pal_id", int'(want.pal_id), int'(result.pal_id));
          check_field("distinct_count", int'(want.distinct_count),
                      int'(result.distinct_count));
          check_field("overflow", int'(want.overflow), int'(result.overflow));
        end
      end
      result_stall <= idle_now();
    end
  end

  task automatic test_directed();
    int word_a [] = '{0, 1, 0, 2, 0, 1, 0};
    send_word(0, 1'b0);
    foreach (word_a[i]) send_word(word_a[i], 1'b0);
    send_word(25, 1'b0);
    send_word(31, 1'b0);
    send_word(26, 1'b0);
    send_word(30, 1'b1);
    send_word(21, 1'b0);
    send_word(10, 1'b0);
    send_word(21, 1'b0);
    send_word(0, 1'b1);
    send_word(0, 1'b0);
    send_word(0, 1'b0);
  endtask

  task automatic test_capacity();
    send_word($urandom_range(1, 0), 1'b1);
    for (int i = 1; i < ptb_pkg::MAX_LEN + 6; i++) send_word($urandom_range(1, 0), 1'b0);
    send_word(31, 1'b0);
    send_word(3, 1'b1);
    send_word(3, 1'b0);
  endtask

  task automatic test_random();
    int span;
    span = 2;
    for (int i = 0; i < 250; i++) begin
      quiet = (i >= 80 && i < 180);
      if (i % 60 == 0) span = $urandom_range(3) == 0 ? 32 : $urandom_range(6, 2);
      send_word($urandom_range(span - 1), $urandom_range(39) == 0);
    end
    quiet = 0;
  endtask

  initial begin
    wipe_tree();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) $display("palindromic_tree_builder_core_test: PASS");
    else $display("palindromic_tree_builder_core_test: FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("palindromic_tree_builder_core_test: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ptb_pkg.sv
rtl/ptb_ram.sv
rtl/palindromic_tree_builder_core.sv
bench/palindromic_tree_builder_core_test.sv
